@@ src/i2cee_pkg.sv @@
`default_nettype none
package i2cee_pkg;

   localparam int PAGE_BYTES = 32;
   localparam int PAGE_AW = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
   localparam int LOAD_W = $clog2(PAGE_BYTES + 1);
   localparam logic [1:0] MAX_ATTEMPTS = 2'd3;

   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_LOAD  = 2'd1;
   localparam logic [1:0] ACT_WRITE = 2'd2;
   localparam logic [1:0] ACT_READ  = 2'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FAIL = 2'd1;
   localparam logic [1:0] ST_PAGE = 2'd2;

   localparam logic [1:0] CSR_ADDR_BYTES = 2'd0;
   localparam logic [1:0] CSR_HALF       = 2'd1;
   localparam logic [1:0] CSR_ACK_WAIT   = 2'd2;
   localparam logic [1:0] CSR_POLL       = 2'd3;

   typedef enum logic [14:0] {
      PH_IDLE      = 15'h0001,
      PH_START_A   = 15'h0002,
      PH_START_B   = 15'h0004,
      PH_TX_LOW    = 15'h0008,
      PH_TX_HIGH   = 15'h0010,
      PH_ACK_LOW   = 15'h0020,
      PH_ACK_HIGH  = 15'h0040,
      PH_RS_LOW    = 15'h0080,
      PH_RX_LOW    = 15'h0100,
      PH_RX_HIGH   = 15'h0200,
      PH_MACK_LOW  = 15'h0400,
      PH_MACK_HIGH = 15'h0800,
      PH_STOP_A    = 15'h1000,
      PH_STOP_B    = 15'h2000,
      PH_STOP_C    = 15'h4000
   } phase_type;

   typedef enum logic [2:0] {
      SG_DEV  = 3'd0,
      SG_AH   = 3'd1,
      SG_AL   = 3'd2,
      SG_RDEV = 3'd3,
      SG_DATA = 3'd4,
      SG_POLL = 3'd5
   } stage_type;

   typedef enum logic [2:0] {
      OUT_FAIL      = 3'd0,
      OUT_WRITE_OK  = 3'd1,
      OUT_READ_OK   = 3'd2,
      OUT_POLL_ACK  = 3'd3,
      OUT_POLL_NACK = 3'd4
   } outcome_type;

   typedef struct packed {
      logic [1:0]  addr_bytes;
      logic [7:0]  half_period_ticks;
      logic [7:0]  ack_wait_limit;
      logic [15:0] poll_limit;
   } csr_type;

   typedef struct packed {
      logic       we;
      logic [PAGE_AW-1:0] waddr;
      logic [7:0] wdata;
      logic [PAGE_AW-1:0] raddr;
   } buf_ctl_type;

endpackage
`default_nettype wire

@@ src/i2cee_ram.sv @@
`default_nettype none
module i2cee_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

@@ src/i2cee_csr.sv @@
`default_nettype none
module i2cee_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   output i2cee_pkg::csr_type csr
);
   i2cee_pkg::csr_type csr_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.addr_bytes        <= 2'd2;
         csr_ff.half_period_ticks <= 8'd4;
         csr_ff.ack_wait_limit    <= 8'd10;
         csr_ff.poll_limit        <= 16'd8000;
      end else if (csr_we) begin
         unique case (csr_index)
            i2cee_pkg::CSR_ADDR_BYTES: csr_ff.addr_bytes <= csr_wdata[1:0];
            i2cee_pkg::CSR_HALF:       csr_ff.half_period_ticks <= csr_wdata[7:0];
            i2cee_pkg::CSR_ACK_WAIT:   csr_ff.ack_wait_limit <= csr_wdata[7:0];
            i2cee_pkg::CSR_POLL:       csr_ff.poll_limit <= csr_wdata;
            default: ;
         endcase
      end
   end
   assign csr = csr_ff;
endmodule
`default_nettype wire

@@ src/i2cee_core.sv @@
`default_nettype none
module i2cee_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire i2cee_pkg::csr_type csr,
   input  wire logic        step,
   input  wire logic [1:0]  action,
   input  wire logic [7:0]  device_addr,
   input  wire logic [15:0] mem_addr,
   input  wire logic [15:0] byte_count,
   input  wire logic [7:0]  data_byte,
   input  wire logic        sda_sample,
   input  wire logic [7:0]  buf_rdata,
   output i2cee_pkg::buf_ctl_type buf_ctl,
   output logic        o_scl,
   output logic        o_sda,
   output logic        o_busy,
   output logic [7:0]  o_rd_data,
   output logic        o_rd_valid,
   output logic        o_rd_last,
   output logic        o_done,
   output logic [1:0]  o_status
);
   localparam int AW = i2cee_pkg::PAGE_AW;
   localparam int LW = i2cee_pkg::LOAD_W;

   i2cee_pkg::phase_type   phase_ff, phase_in;
   i2cee_pkg::stage_type   stage_ff, stage_in;
   i2cee_pkg::outcome_type outcome_ff, outcome_in;
   logic [15:0] tick_ff, tick_in;
   logic [3:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] idx_ff, idx_in;
   logic [1:0]  attempt_ff, attempt_in;
   logic [LW-1:0] load_ff, load_in;
   logic [7:0]  dev_ff, dev_in;
   logic [15:0] addr_ff, addr_in;
   logic [15:0] len_ff, len_in;
   logic        rd_ff, rd_in;
   logic        poll_ff, poll_in;
   logic [15:0] pused_ff, pused_in;

   logic [15:0] h, tinc, twait;
   logic        fin, last_b;
   logic [7:0]  shifted_rx;
   logic [16:0] idx_p1;
   logic        rdv, rdl, done;
   logic [7:0]  rdd;
   logic [1:0]  st;
   logic [15:0] idx_nx;

   // Keep the RAM addressed at the next data byte so it is ready at the acknowledge.
   assign h = (csr.half_period_ticks == 8'd0) ? 16'd1 : {8'd0, csr.half_period_ticks};
   assign tinc = (tick_ff == 16'hFFFF) ? tick_ff : tick_ff + 16'd1;
   assign fin = tinc >= h;
   assign twait = tinc - h;
   assign idx_p1 = {1'b0, idx_ff} + 17'd1;
   assign last_b = idx_p1 >= {1'b0, len_ff};
   assign shifted_rx = {shift_ff[6:0], sda_sample};

   always_comb begin
      phase_in = phase_ff; stage_in = stage_ff; outcome_in = outcome_ff;
      tick_in = tick_ff; bit_in = bit_ff; shift_in = shift_ff; idx_in = idx_ff;
      attempt_in = attempt_ff; load_in = load_ff; dev_in = dev_ff;
      addr_in = addr_ff; len_in = len_ff; rd_in = rd_ff; poll_in = poll_ff;
      pused_in = pused_ff;
      rdv = 1'b0; rdl = 1'b0; rdd = 8'd0; done = 1'b0; st = i2cee_pkg::ST_OK;
      idx_nx = idx_ff;
      buf_ctl.we = 1'b0;
      buf_ctl.waddr = load_ff[AW-1:0];
      buf_ctl.wdata = data_byte;
      buf_ctl.raddr = (stage_ff == i2cee_pkg::SG_DATA) ? idx_p1[AW-1:0] : idx_ff[AW-1:0];
      if (step) begin
         if (phase_ff == i2cee_pkg::PH_IDLE) begin
            unique case (action)
               i2cee_pkg::ACT_LOAD: begin
                  if (load_ff < LW'(i2cee_pkg::PAGE_BYTES)) begin
                     buf_ctl.we = 1'b1;
                     load_in = load_ff + LW'(1);
                  end
               end
               i2cee_pkg::ACT_WRITE, i2cee_pkg::ACT_READ: begin
                  if (action == i2cee_pkg::ACT_WRITE) begin
                     load_in = '0;
                  end
                  if (action == i2cee_pkg::ACT_WRITE &&
                      byte_count > 16'(i2cee_pkg::PAGE_BYTES)) begin
                     done = 1'b1; st = i2cee_pkg::ST_PAGE;
                  end else begin
                     dev_in = device_addr; addr_in = mem_addr; len_in = byte_count;
                     rd_in = (action == i2cee_pkg::ACT_READ);
                     attempt_in = '0; idx_in = '0; bit_in = '0; shift_in = '0;
                     poll_in = 1'b0; pused_in = '0; stage_in = i2cee_pkg::SG_DEV;
                     phase_in = i2cee_pkg::PH_START_A; tick_in = '0;
                  end
               end
               default: ;
            endcase
         end else begin
            if (poll_ff && pused_ff != 16'hFFFF) pused_in = pused_ff + 16'd1;
            tick_in = tinc;
            unique case (phase_ff)
               i2cee_pkg::PH_START_A: if (fin) begin
                  phase_in = i2cee_pkg::PH_START_B; tick_in = '0;
               end
               i2cee_pkg::PH_START_B: if (fin) begin
                  bit_in = '0; phase_in = i2cee_pkg::PH_TX_LOW; tick_in = '0;
                  unique case (stage_ff)
                     i2cee_pkg::SG_AH:   shift_in = addr_ff[15:8];
                     i2cee_pkg::SG_AL:   shift_in = addr_ff[7:0];
                     i2cee_pkg::SG_RDEV: shift_in = dev_ff | 8'h01;
                     default:            shift_in = dev_ff;
                  endcase
               end
               i2cee_pkg::PH_TX_LOW: if (fin) begin
                  phase_in = i2cee_pkg::PH_TX_HIGH; tick_in = '0;
               end
               i2cee_pkg::PH_TX_HIGH: if (fin) begin
                  shift_in = {shift_ff[6:0], 1'b0};
                  bit_in = bit_ff + 4'd1;
                  phase_in = (bit_ff >= 4'd7) ? i2cee_pkg::PH_ACK_LOW
                                              : i2cee_pkg::PH_TX_LOW;
                  tick_in = '0;
               end
               i2cee_pkg::PH_ACK_LOW: if (fin) begin
                  phase_in = i2cee_pkg::PH_ACK_HIGH; tick_in = '0;
               end
               i2cee_pkg::PH_ACK_HIGH: if (fin) begin
                  if (!sda_sample) begin
                     tick_in = '0;
                     case (stage_ff)
                        i2cee_pkg::SG_DEV: begin
                           stage_in = (csr.addr_bytes >= 2'd2) ? i2cee_pkg::SG_AH
                                                               : i2cee_pkg::SG_AL;
                           shift_in = (csr.addr_bytes >= 2'd2) ? addr_ff[15:8]
                                                               : addr_ff[7:0];
                           bit_in = '0; phase_in = i2cee_pkg::PH_TX_LOW;
                        end
                        i2cee_pkg::SG_AH: begin
                           stage_in = i2cee_pkg::SG_AL; shift_in = addr_ff[7:0];
                           bit_in = '0; phase_in = i2cee_pkg::PH_TX_LOW;
                        end
                        i2cee_pkg::SG_AL: begin
                           if (rd_ff) begin
                              phase_in = i2cee_pkg::PH_RS_LOW;
                           end else if (len_ff != 16'd0) begin
                              idx_in = '0; shift_in = buf_rdata;
                              stage_in = i2cee_pkg::SG_DATA;
                              bit_in = '0; phase_in = i2cee_pkg::PH_TX_LOW;
                           end else begin
                              outcome_in = i2cee_pkg::OUT_WRITE_OK;
                              phase_in = i2cee_pkg::PH_STOP_A;
                           end
                        end
                        i2cee_pkg::SG_RDEV: begin
                           if (len_ff != 16'd0) begin
                              idx_in = '0; bit_in = '0; shift_in = '0;
                              phase_in = i2cee_pkg::PH_RX_LOW;
                           end else begin
                              outcome_in = i2cee_pkg::OUT_READ_OK;
                              phase_in = i2cee_pkg::PH_STOP_A;
                           end
                        end
                        i2cee_pkg::SG_DATA: begin
                           idx_nx = idx_p1[15:0];
                           idx_in = idx_nx;
                           if (idx_nx < len_ff) begin
                              shift_in = buf_rdata;
                              bit_in = '0; phase_in = i2cee_pkg::PH_TX_LOW;
                           end else begin
                              outcome_in = i2cee_pkg::OUT_WRITE_OK;
                              phase_in = i2cee_pkg::PH_STOP_A;
                           end
                        end
                        default: begin
                           outcome_in = i2cee_pkg::OUT_POLL_ACK;
                           phase_in = i2cee_pkg::PH_STOP_A;
                        end
                     endcase
                  end else if (twait >= {8'd0, csr.ack_wait_limit}) begin
                     outcome_in = poll_ff ? i2cee_pkg::OUT_POLL_NACK
                                          : i2cee_pkg::OUT_FAIL;
                     phase_in = i2cee_pkg::PH_STOP_A; tick_in = '0;
                  end
               end
               i2cee_pkg::PH_RS_LOW: if (fin) begin
                  stage_in = i2cee_pkg::SG_RDEV;
                  phase_in = i2cee_pkg::PH_START_A; tick_in = '0;
               end
               i2cee_pkg::PH_RX_LOW: if (fin) begin
                  phase_in = i2cee_pkg::PH_RX_HIGH; tick_in = '0;
               end
               i2cee_pkg::PH_RX_HIGH: if (fin) begin
                  shift_in = shifted_rx;
                  bit_in = bit_ff + 4'd1;
                  tick_in = '0;
                  if (bit_ff >= 4'd7) begin
                     rdv = 1'b1; rdd = shifted_rx; rdl = last_b;
                     phase_in = i2cee_pkg::PH_MACK_LOW;
                  end else begin
                     phase_in = i2cee_pkg::PH_RX_LOW;
                  end
               end
               i2cee_pkg::PH_MACK_LOW: if (fin) begin
                  phase_in = i2cee_pkg::PH_MACK_HIGH; tick_in = '0;
               end
               i2cee_pkg::PH_MACK_HIGH: if (fin) begin
                  idx_in = idx_p1[15:0]; tick_in = '0;
                  if (idx_p1[15:0] < len_ff) begin
                     bit_in = '0; shift_in = '0; phase_in = i2cee_pkg::PH_RX_LOW;
                  end else begin
                     outcome_in = i2cee_pkg::OUT_READ_OK;
                     phase_in = i2cee_pkg::PH_STOP_A;
                  end
               end
               i2cee_pkg::PH_STOP_A: if (fin) begin
                  phase_in = i2cee_pkg::PH_STOP_B; tick_in = '0;
               end
               i2cee_pkg::PH_STOP_B: if (fin) begin
                  phase_in = i2cee_pkg::PH_STOP_C; tick_in = '0;
               end
               i2cee_pkg::PH_STOP_C: if (fin) begin
                  tick_in = '0;
                  if (outcome_ff == i2cee_pkg::OUT_FAIL) begin
                     attempt_in = attempt_ff + 2'd1;
                     if (attempt_ff + 2'd1 >= i2cee_pkg::MAX_ATTEMPTS) begin
                        phase_in = i2cee_pkg::PH_IDLE; done = 1'b1;
                        st = i2cee_pkg::ST_FAIL; poll_in = 1'b0;
                     end else begin
                        idx_in = '0; stage_in = i2cee_pkg::SG_DEV;
                        phase_in = i2cee_pkg::PH_START_A;
                     end
                  end else if (outcome_ff == i2cee_pkg::OUT_WRITE_OK) begin
                     poll_in = 1'b1; pused_in = '0;
                     stage_in = i2cee_pkg::SG_POLL; phase_in = i2cee_pkg::PH_START_A;
                  end else if (outcome_ff == i2cee_pkg::OUT_POLL_NACK &&
                               pused_in < csr.poll_limit) begin
                     stage_in = i2cee_pkg::SG_POLL; phase_in = i2cee_pkg::PH_START_A;
                  end else begin
                     phase_in = i2cee_pkg::PH_IDLE; done = 1'b1; poll_in = 1'b0;
                  end
               end
               default: begin
                  phase_in = i2cee_pkg::PH_IDLE; tick_in = '0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= i2cee_pkg::PH_IDLE; stage_ff <= i2cee_pkg::SG_DEV;
         outcome_ff <= i2cee_pkg::OUT_FAIL; tick_ff <= '0; bit_ff <= '0;
         shift_ff <= '0; idx_ff <= '0; attempt_ff <= '0; load_ff <= '0;
         dev_ff <= '0; addr_ff <= '0; len_ff <= '0; rd_ff <= 1'b0;
         poll_ff <= 1'b0; pused_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in; stage_ff <= stage_in; outcome_ff <= outcome_in;
         tick_ff <= tick_in; bit_ff <= bit_in; shift_ff <= shift_in;
         idx_ff <= idx_in; attempt_ff <= attempt_in; load_ff <= load_in;
         dev_ff <= dev_in; addr_ff <= addr_in; len_ff <= len_in; rd_ff <= rd_in;
         poll_ff <= poll_in; pused_ff <= pused_in;
      end
   end

   logic [7:0] sh_out;
   logic       last_out;
   logic [16:0] idx_in_p1;
   assign idx_in_p1 = {1'b0, idx_in} + 17'd1;
   assign last_out = idx_in_p1 >= {1'b0, len_in};

   // The line levels follow the next state.
   assign sh_out = shift_in;

   always_comb begin
      o_scl = 1'b1; o_sda = 1'b1;
      unique case (phase_in)
         i2cee_pkg::PH_START_B: begin o_scl = 1'b1; o_sda = 1'b0; end
         i2cee_pkg::PH_TX_LOW:  begin o_scl = 1'b0; o_sda = sh_out[7]; end
         i2cee_pkg::PH_TX_HIGH: begin o_scl = 1'b1; o_sda = sh_out[7]; end
         i2cee_pkg::PH_ACK_LOW, i2cee_pkg::PH_RS_LOW, i2cee_pkg::PH_RX_LOW: begin
            o_scl = 1'b0; o_sda = 1'b1;
         end
         i2cee_pkg::PH_MACK_LOW:  begin o_scl = 1'b0; o_sda = last_out; end
         i2cee_pkg::PH_MACK_HIGH: begin o_scl = 1'b1; o_sda = last_out; end
         i2cee_pkg::PH_STOP_A: begin o_scl = 1'b0; o_sda = 1'b0; end
         i2cee_pkg::PH_STOP_B: begin o_scl = 1'b1; o_sda = 1'b0; end
         default: ;
      endcase
      o_busy = (phase_in != i2cee_pkg::PH_IDLE);
      o_rd_data = rdd; o_rd_valid = rdv; o_rd_last = rdl;
      o_done = done; o_status = st;
   end
endmodule
`default_nettype wire

@@ src/i2c_eeprom_master.sv @@
// channel | ports                                   | direction
// req     | req_valid/req_stall, action..sda_sample | in, one tick or command per word
// rsp     | rsp_valid/rsp_stall, scl..status        | out, one word per req word
// csr     | csr_we, csr_index, csr_wdata            | in, write only
// Each req word is processed combinationally and its rsp word is registered.
// A word is taken whenever the output register is empty or being drained.
// The page buffer is a 32-byte RAM; the next data byte is addressed ahead through its registered read.
// Reset is synchronous; it clears all control state and sets the CSRs to their defaults.
`default_nettype none
module i2c_eeprom_master (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [7:0]  req_device_addr,
   input  wire logic [15:0] req_mem_addr,
   input  wire logic [15:0] req_byte_count,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_sda_sample,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_scl,
   output logic             rsp_sda_release,
   output logic             rsp_busy_res,
   output logic [7:0]       rsp_rd_data,
   output logic             rsp_rd_valid,
   output logic             rsp_rd_last,
   output logic             rsp_done_res,
   output logic [1:0]       rsp_status
);
   i2cee_pkg::csr_type     csr;
   i2cee_pkg::buf_ctl_type buf_ctl;
   logic [7:0] buf_rdata;
   logic step;
   logic c_scl, c_sda, c_busy, c_rdv, c_rdl, c_done;
   logic [7:0] c_rdd;
   logic [1:0] c_st;
   logic valid_ff;

   assign req_stall = valid_ff && rsp_stall;
   assign step = req_valid && !req_stall;

   i2cee_csr u_csr (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata, .csr
   );

   i2cee_ram #(.WIDTH(8), .DEPTH(i2cee_pkg::PAGE_BYTES)) u_buf (
      .clock, .we(buf_ctl.we && step), .waddr(buf_ctl.waddr), .wdata(buf_ctl.wdata),
      .raddr(buf_ctl.raddr), .rdata(buf_rdata)
   );

   i2cee_core u_core (
      .clock, .reset, .csr, .step,
      .action(req_action), .device_addr(req_device_addr), .mem_addr(req_mem_addr),
      .byte_count(req_byte_count), .data_byte(req_data_byte),
      .sda_sample(req_sda_sample), .buf_rdata, .buf_ctl,
      .o_scl(c_scl), .o_sda(c_sda), .o_busy(c_busy), .o_rd_data(c_rdd),
      .o_rd_valid(c_rdv), .o_rd_last(c_rdl), .o_done(c_done), .o_status(c_st)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (step) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_scl <= c_scl; rsp_sda_release <= c_sda; rsp_busy_res <= c_busy;
         rsp_rd_data <= c_rdd; rsp_rd_valid <= c_rdv; rsp_rd_last <= c_rdl;
         rsp_done_res <= c_done; rsp_status <= c_st;
      end
   end

   assign rsp_valid = valid_ff;
endmodule
`default_nettype wire

@@ src/i2cee_checker.sv @@
`default_nettype none
module i2cee_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_done_res,
   input wire logic       rsp_rd_valid,
   input wire logic       rsp_rd_last,
   input wire logic [1:0] rsp_status
);
   a_word_out: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid) else $error("rsp word missing");
   a_stall_rel: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid) |-> !req_stall) else $error("stall without rsp word");
   a_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_done_res) |-> (rsp_status == 2'd0)) else $error("status");
   a_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_rd_last) |-> rsp_rd_valid) else $error("rd_last");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status)))
      else $error("rsp word dropped");
endmodule

bind i2c_eeprom_master i2cee_checker u_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_done_res, .rsp_rd_valid, .rsp_rd_last, .rsp_status
);
`default_nettype wire
